/* sv/bas_pkg.sv */
// Shared widths, types and register indexes for the burst address sequencer.
// No dependencies; imported by burst_address_sequencer.
`default_nettype none

package bas_pkg;

  localparam int ADDR_BITS   = 14;
  localparam int REPEAT_BITS = 16;
  localparam int PERIOD_BITS = 32;
  localparam int COUNT_BITS  = 16;

  // config port: four registers, data as wide as the widest one
  localparam int CFG_REGS      = 4;
  localparam int CFG_IDX_BITS  = $clog2(CFG_REGS);
  localparam int CFG_DATA_BITS = PERIOD_BITS;

  typedef logic [ADDR_BITS-1:0]     addr_t;
  typedef logic [REPEAT_BITS-1:0]   repeat_t;
  typedef logic [PERIOD_BITS-1:0]   period_t;
  typedef logic [COUNT_BITS-1:0]    count_t;
  typedef logic [CFG_IDX_BITS-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;

  localparam cfg_idx_t REG_REPEATS = cfg_idx_t'(0);
  localparam cfg_idx_t REG_LENGTH  = cfg_idx_t'(1);
  localparam cfg_idx_t REG_PERIOD  = cfg_idx_t'(2);
  localparam cfg_idx_t REG_PERIODS = cfg_idx_t'(3);

endpackage

`default_nettype wire

/* sv/burst_address_sequencer.sv */
// Burst address sequencer: one buffer address per sample tick word.
// Depends on bas_pkg for widths, types and config register indexes.
// The result is registered and is valid in the cycle after the input is accepted.
// Throughput: one word per cycle while out_ready holds; the sequence counters
// and the result register update in the same cycle, and in_ready follows the
// result register (free, or being drained this cycle).
// Reset (rst_n, synchronous): config registers and all counters go to zero,
// the burst starts at period zero, and the result register is emptied.
`default_nettype none

module burst_address_sequencer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // config write port
  input  wire logic              cfg_we,
  input  wire bas_pkg::cfg_idx_t cfg_index,
  input  wire bas_pkg::cfg_data_t cfg_data,
  // sample tick input
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_restart,
  // address output
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bas_pkg::addr_t         out_address,
  output logic                   out_active,
  output logic                   out_period_end,
  output logic                   out_burst_end
);

  import bas_pkg::*;

  // config registers
  repeat_t repeats_m1_r;
  addr_t   length_m1_r;
  period_t period_m1_r;
  count_t  periods_m1_r;

  // sequence state
  repeat_t repeat_count_r, repeat_count_nxt;
  addr_t   data_index_r,   data_index_nxt;
  period_t period_pos_r,   period_pos_nxt;
  count_t  period_count_r, period_count_nxt;
  logic    finished_r,     finished_nxt;

  // result register
  logic    out_valid_r;
  addr_t   out_address_r,    address_nxt;
  logic    out_active_r,     active_nxt;
  logic    out_period_end_r, period_end_nxt;
  logic    out_burst_end_r,  burst_end_nxt;

  // effective state after an optional restart
  repeat_t rc_eff;
  addr_t   di_eff;
  period_t pos_eff;
  count_t  pc_eff;
  logic    fin_eff;
  logic    pend;
  logic    accept;

  // result slot is free or drains this cycle
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    rc_eff  = in_restart ? '0 : repeat_count_r;
    di_eff  = in_restart ? '0 : data_index_r;
    pos_eff = in_restart ? '0 : period_pos_r;
    pc_eff  = in_restart ? '0 : period_count_r;
    fin_eff = in_restart ? 1'b0 : finished_r;

    pend = (pos_eff >= period_m1_r);

    repeat_count_nxt = rc_eff;
    data_index_nxt   = di_eff;
    period_pos_nxt   = pos_eff;
    period_count_nxt = pc_eff;
    finished_nxt     = fin_eff;

    address_nxt    = '0;
    active_nxt     = 1'b0;
    period_end_nxt = 1'b0;
    burst_end_nxt  = 1'b0;

    if (!fin_eff) begin
      // clamp in case length was lowered mid-burst
      address_nxt    = (di_eff > length_m1_r) ? length_m1_r : di_eff;
      active_nxt     = 1'b1;
      period_end_nxt = pend;

      if (pend) begin
        period_pos_nxt   = '0;
        repeat_count_nxt = '0;
        data_index_nxt   = '0;
        if (pc_eff >= periods_m1_r) begin
          finished_nxt  = 1'b1;
          burst_end_nxt = 1'b1;
        end else begin
          period_count_nxt = pc_eff + count_t'(1);
        end
      end else begin
        period_pos_nxt = pos_eff + period_t'(1);
        if (rc_eff >= repeats_m1_r) begin
          repeat_count_nxt = '0;
          // fill part: index parks on the last data address
          if (di_eff < length_m1_r) begin
            data_index_nxt = di_eff + addr_t'(1);
          end
        end else begin
          repeat_count_nxt = rc_eff + repeat_t'(1);
        end
      end
    end
  end

  // config writes, masked to register widths
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeats_m1_r <= '0;
      length_m1_r  <= '0;
      period_m1_r  <= '0;
      periods_m1_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REPEATS: repeats_m1_r <= cfg_data[REPEAT_BITS-1:0];
        REG_LENGTH:  length_m1_r  <= cfg_data[ADDR_BITS-1:0];
        REG_PERIOD:  period_m1_r  <= cfg_data[PERIOD_BITS-1:0];
        REG_PERIODS: periods_m1_r <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequence state advances once per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_count_r <= '0;
      data_index_r   <= '0;
      period_pos_r   <= '0;
      period_count_r <= '0;
      finished_r     <= 1'b0;
    end else if (accept) begin
      repeat_count_r <= repeat_count_nxt;
      data_index_r   <= data_index_nxt;
      period_pos_r   <= period_pos_nxt;
      period_count_r <= period_count_nxt;
      finished_r     <= finished_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_address_r    <= address_nxt;
      out_active_r     <= active_nxt;
      out_period_end_r <= period_end_nxt;
      out_burst_end_r  <= burst_end_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_address    = out_address_r;
  assign out_active     = out_active_r;
  assign out_period_end = out_period_end_r;
  assign out_burst_end  = out_burst_end_r;

endmodule

`default_nettype wire
